[rtl/core/pll_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_pkg: shared types and constants of the pooled linked list engine
// Command and status codes, the sequencer states and the result beat
// carried from the sequencer to the output register.
// ----------------------------------------------------------------------------
package pll_pkg;

  // fixed field widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;

  // read-out limit and the element counter that tracks it
  localparam int MAX_RESULTS = 63;
  localparam int CNT_W       = 6;

  // command codes, codes six and seven are unused
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_ADD_FRONT = 3'd1,
    CMD_ADD_BACK  = 3'd2,
    CMD_ADD_POS   = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_READ      = 3'd5
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL,
    S_POS,
    S_LINK,
    S_REMOVE,
    S_READ
  } state_e;

  // one result beat
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic               last;
  } res_t;

endpackage

[rtl/core/pll_node_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_node_mem: node pool storage
// Value and link arrays of the node pool, each with one write port and one
// registered read port sharing a single read address.
// ----------------------------------------------------------------------------
module pll_node_mem #(
  parameter int POOL_NODES = 64
) (
  input  logic                              clk_i,
  input  logic                              wv_en_i,
  input  logic [$clog2(POOL_NODES)-1:0]     wv_addr_i,
  input  logic [pll_pkg::VALUE_W-1:0]       wv_data_i,
  input  logic                              wl_en_i,
  input  logic [$clog2(POOL_NODES)-1:0]     wl_addr_i,
  input  logic [$clog2(POOL_NODES)-1:0]     wl_data_i,
  input  logic [$clog2(POOL_NODES)-1:0]     raddr_i,
  output logic [pll_pkg::VALUE_W-1:0]       rd_val_o,
  output logic [$clog2(POOL_NODES)-1:0]     rd_link_o
);
  import pll_pkg::*;

  localparam int LW = $clog2(POOL_NODES);

  logic [VALUE_W-1:0] val_mem  [POOL_NODES];
  logic [LW-1:0]      link_mem [POOL_NODES];
  logic [VALUE_W-1:0] rd_val_q;
  logic [LW-1:0]      rd_link_q;

  // value array
  always_ff @(posedge clk_i) begin
    if (wv_en_i) begin
      val_mem[wv_addr_i] <= wv_data_i;
    end
    rd_val_q <= val_mem[raddr_i];
  end

  // link array
  always_ff @(posedge clk_i) begin
    if (wl_en_i) begin
      link_mem[wl_addr_i] <= wl_data_i;
    end
    rd_link_q <= link_mem[raddr_i];
  end

  assign rd_val_o  = rd_val_q;
  assign rd_link_o = rd_link_q;

endmodule

[rtl/core/pll_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_seq: list walk sequencer
// Decodes commands, allocates nodes from the bump counter and walks the
// list one node per cycle through the pool read port, comparing each
// node against the search value with one shared comparator.
// ----------------------------------------------------------------------------
module pll_seq #(
  parameter int POOL_NODES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pll_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [pll_pkg::VALUE_W-1:0] value_i,
  input  logic [pll_pkg::POS_W-1:0]         position_i,
  output logic                              wv_en_o,
  output logic [$clog2(POOL_NODES)-1:0]     wv_addr_o,
  output logic [pll_pkg::VALUE_W-1:0]       wv_data_o,
  output logic                              wl_en_o,
  output logic [$clog2(POOL_NODES)-1:0]     wl_addr_o,
  output logic [$clog2(POOL_NODES)-1:0]     wl_data_o,
  output logic [$clog2(POOL_NODES)-1:0]     raddr_o,
  input  logic [pll_pkg::VALUE_W-1:0]       rd_val_i,
  input  logic [$clog2(POOL_NODES)-1:0]     rd_link_i,
  output pll_pkg::res_t                     res_o
);
  import pll_pkg::*;

  localparam int LW = $clog2(POOL_NODES);
  localparam int AW = $clog2(POOL_NODES + 1);

  state_e             state_q, state_d;
  logic [LW-1:0]      head_q, head_d;
  logic [AW-1:0]      alloc_q, alloc_d;
  logic [LW-1:0]      cur_q, cur_d;
  logic [LW-1:0]      prev_q, prev_d;
  logic [LW-1:0]      new_q, new_d;
  logic [POS_W-1:0]   rem_q, rem_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   k_q, k_d;

  logic               accept;
  logic               full;
  logic [LW-1:0]      fresh;
  logic               hit;
  logic               rd_end;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (alloc_q == AW'(POOL_NODES));
  assign fresh  = alloc_q[LW-1:0];
  assign hit    = (rd_val_i == val_q);
  assign rd_end = (rd_link_i == '0);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      alloc_q <= AW'(1);
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      alloc_q <= alloc_d;
    end
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    new_q  <= new_d;
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    k_q    <= k_d;
  end

  // next state, pool accesses and result beat
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    alloc_d   = alloc_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    new_d     = new_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    val_d     = val_q;
    k_d       = k_q;
    wv_en_o   = 1'b0;
    wv_addr_o = fresh;
    wv_data_o = value_i;
    wl_en_o   = 1'b0;
    wl_addr_o = '0;
    wl_data_o = '0;
    raddr_o   = '0;
    res_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = position_i;
          val_d = value_i;
          case (cmd_i)
            CMD_CLEAR: begin
              head_d     = '0;
              alloc_d    = AW'(1);
              res_o.valid = 1'b1;
              res_o.last  = 1'b1;
            end
            CMD_ADD_FRONT: begin
              res_o.valid = 1'b1;
              res_o.last  = 1'b1;
              if (full) begin
                res_o.status = ST_FULL;
              end else begin
                wv_en_o   = 1'b1;
                wl_en_o   = 1'b1;
                wl_addr_o = fresh;
                wl_data_o = head_q;
                head_d    = fresh;
                alloc_d   = alloc_q + AW'(1);
              end
            end
            CMD_ADD_BACK: begin
              if (full) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_FULL;
              end else begin
                wv_en_o   = 1'b1;
                wl_en_o   = 1'b1;
                wl_addr_o = fresh;
                wl_data_o = '0;
                alloc_d   = alloc_q + AW'(1);
                new_d     = fresh;
                if (head_q == '0) begin
                  head_d      = fresh;
                  res_o.valid = 1'b1;
                  res_o.last  = 1'b1;
                end else begin
                  cur_d   = head_q;
                  raddr_o = head_q;
                  state_d = S_TAIL;
                end
              end
            end
            CMD_ADD_POS: begin
              if (full) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_FULL;
              end else begin
                wv_en_o = 1'b1;
                alloc_d = alloc_q + AW'(1);
                new_d   = fresh;
                if (head_q == '0 || position_i == POS_W'(1)) begin
                  // new node goes straight after the sentinel
                  wl_en_o     = 1'b1;
                  wl_addr_o   = fresh;
                  wl_data_o   = head_q;
                  head_d      = fresh;
                  res_o.valid = 1'b1;
                  res_o.last  = 1'b1;
                end else begin
                  cur_d   = head_q;
                  raddr_o = head_q;
                  rem_d   = position_i - POS_W'(2);
                  state_d = S_POS;
                end
              end
            end
            CMD_REMOVE: begin
              if (head_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_NOT_FOUND;
              end else begin
                prev_d  = '0;
                cur_d   = head_q;
                raddr_o = head_q;
                state_d = S_REMOVE;
              end
            end
            CMD_READ: begin
              if (head_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                raddr_o = head_q;
                k_d     = '0;
                state_d = S_READ;
              end
            end
            default: begin
              res_o.valid = 1'b1;
              res_o.last  = 1'b1;
            end
          endcase
        end
      end
      // walk to the tail, then hook the new node on
      S_TAIL: begin
        if (rd_end) begin
          wl_en_o     = 1'b1;
          wl_addr_o   = cur_q;
          wl_data_o   = new_q;
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          cur_d   = rd_link_i;
          raddr_o = rd_link_i;
        end
      end
      // walk to the insert point, new node takes the successor first
      S_POS: begin
        if (rd_end || (pos_q != '0 && rem_q == '0)) begin
          wl_en_o   = 1'b1;
          wl_addr_o = new_q;
          wl_data_o = rd_link_i;
          state_d   = S_LINK;
        end else begin
          cur_d   = rd_link_i;
          raddr_o = rd_link_i;
          rem_d   = rem_q - POS_W'(1);
        end
      end
      // predecessor points to the new node
      S_LINK: begin
        wl_en_o     = 1'b1;
        wl_addr_o   = cur_q;
        wl_data_o   = new_q;
        res_o.valid = 1'b1;
        res_o.last  = 1'b1;
        state_d     = S_IDLE;
      end
      // search and unlink the first match
      S_REMOVE: begin
        if (hit) begin
          if (prev_q == '0) begin
            head_d = rd_link_i;
          end else begin
            wl_en_o   = 1'b1;
            wl_addr_o = prev_q;
            wl_data_o = rd_link_i;
          end
          res_o.valid = 1'b1;
          res_o.last  = 1'b1;
          state_d     = S_IDLE;
        end else if (rd_end) begin
          res_o.valid  = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          prev_d  = cur_q;
          cur_d   = rd_link_i;
          raddr_o = rd_link_i;
        end
      end
      // one element beat per node
      S_READ: begin
        res_o.valid = 1'b1;
        res_o.value = rd_val_i;
        res_o.last  = rd_end || (k_q == CNT_W'(MAX_RESULTS - 1));
        if (res_o.last) begin
          state_d = S_IDLE;
        end else begin
          raddr_o = rd_link_i;
          k_d     = k_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // only the read-out gives beats that are not final
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && state_q != S_READ) |-> res_o.last)
    else $error("non-final beat outside read-out");

  // clear empties the list and releases the pool
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_CLEAR) |=> (head_q == '0 && alloc_q == AW'(1)))
    else $error("clear did not reset head and allocator");

  // nodes are never reclaimed outside clear
  a_alloc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && cmd_i == CMD_CLEAR) |=> (alloc_q >= $past(alloc_q)))
    else $error("allocation counter went back");

  // a walk never stands on the sentinel
  a_walk_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL || state_q == S_POS || state_q == S_LINK ||
     state_q == S_REMOVE) |-> (cur_q != '0))
    else $error("walk pointer on sentinel");
`endif

endmodule

[rtl/core/pooled_linked_list_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_unit: linked list of signed values in a node pool
// Command port: a command beat is taken when start is high and busy is low.
// Result port: each result beat is on elem_value_o, status_o and last_o for
// one cycle with result_valid_o high; the receiver takes every beat, it
// cannot stall. last_o marks the final beat of a command.
// First beat: result beats are registered; the first one shows in the cycle
// after the accepting edge for clear, add front, add at position one, unused
// codes, a full pool and an empty list. Otherwise it follows the walk for add
// back and remove, the first node read for read-out and the link step for add
// at position. Throughput: the list is walked one node per cycle over the
// single pool read port; read-out gives a beat per node, at most 63 of them.
// busy is high until a walking command has finished; commands without a walk
// leave it low.
// Reset: the list is empty and only the sentinel is allocated; no clearing
// pass runs, a command may be given in the first cycle after reset.
// ----------------------------------------------------------------------------
module pooled_linked_list_engine_unit #(
  parameter int POOL_NODES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [pll_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [pll_pkg::VALUE_W-1:0] value_i,
  input  logic [pll_pkg::POS_W-1:0]          position_i,
  output logic                               result_valid_o,
  output logic signed [pll_pkg::VALUE_W-1:0] elem_value_o,
  output logic [pll_pkg::STATUS_W-1:0]       status_o,
  output logic                               last_o
);
  import pll_pkg::*;

  localparam int LW = $clog2(POOL_NODES);

  logic               wv_en;
  logic [LW-1:0]      wv_addr;
  logic [VALUE_W-1:0] wv_data;
  logic               wl_en;
  logic [LW-1:0]      wl_addr;
  logic [LW-1:0]      wl_data;
  logic [LW-1:0]      raddr;
  logic [VALUE_W-1:0] rd_val;
  logic [LW-1:0]      rd_link;
  res_t               res;

  logic               res_valid_q;
  logic [VALUE_W-1:0] res_value_q;
  status_e            res_status_q;
  logic               res_last_q;

  // sequencer
  pll_seq #(
    .POOL_NODES (POOL_NODES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .position_i (position_i),
    .wv_en_o    (wv_en),
    .wv_addr_o  (wv_addr),
    .wv_data_o  (wv_data),
    .wl_en_o    (wl_en),
    .wl_addr_o  (wl_addr),
    .wl_data_o  (wl_data),
    .raddr_o    (raddr),
    .rd_val_i   (rd_val),
    .rd_link_i  (rd_link),
    .res_o      (res)
  );

  // node pool
  pll_node_mem #(
    .POOL_NODES (POOL_NODES)
  ) u_mem (
    .clk_i     (clk_i),
    .wv_en_i   (wv_en),
    .wv_addr_i (wv_addr),
    .wv_data_i (wv_data),
    .wl_en_i   (wl_en),
    .wl_addr_i (wl_addr),
    .wl_data_i (wl_data),
    .raddr_i   (raddr),
    .rd_val_o  (rd_val),
    .rd_link_o (rd_link)
  );

  // result beat strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res.valid;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    res_value_q  <= res.value;
    res_status_q <= res.status;
    res_last_q   <= res.last;
  end

  assign result_valid_o = res_valid_q;
  assign elem_value_o   = res_value_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

endmodule

[bench/pooled_linked_list_engine_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_unit_test: self-checking bench for the list engine
// Commands go in through the start/busy port from a queue built at time zero.
// A pool-based model of the list predicts every result beat, and each beat
// seen on the result port is compared field by field with the oldest
// prediction. Stimulus: a short directed run over empty lists, extreme
// values, duplicates and spare command codes, then random episodes of
// clear-and-build sequences, some of them long enough to fill the pool.
// ----------------------------------------------------------------------------
module pooled_linked_list_engine_unit_test;
  import pll_pkg::*;

  localparam int POOL_NODES   = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 150;
  localparam int MAX_REPORTS  = 10;

  // spare command codes, the engine answers them with a plain ok beat
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    bit                        drain;
  } list_cmd_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_e                   status;
    logic                      last;
  } list_beat_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start      = 1'b0;
  logic [CMD_W-1:0]          cmd_i      = '0;
  logic signed [VALUE_W-1:0] value_i    = '0;
  logic [POS_W-1:0]          position_i = '0;
  logic                      busy;
  logic                      result_valid_o;
  logic signed [VALUE_W-1:0] elem_value_o;
  logic [STATUS_W-1:0]       status_o;
  logic                      last_o;

  pooled_linked_list_engine_unit #(
    .POOL_NODES(POOL_NODES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .result_valid_o(result_valid_o),
    .elem_value_o  (elem_value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  list_cmd_t  pending_cmds[$];
  list_beat_t expected_beats[$];

  // shadow node pool
  logic signed [VALUE_W-1:0] node_val[POOL_NODES];
  logic [POS_W-1:0]          node_nxt[POOL_NODES];
  int unsigned               nodes_used;

  int mismatch_count = 0;
  int cmds_accepted  = 0;
  int reads_accepted = 0;
  int beats_checked  = 0;
  int full_rejects   = 0;
  int missed_removes = 0;
  int read_run       = 0;
  int longest_read   = 0;
  int stall_cycles   = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // reset, released on a rising clock edge
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // list model
  // ---------------------------------------------------------------------------

  function automatic void pool_reset();
    for (int i = 0; i < POOL_NODES; i++) begin
      node_val[i] = '0;
      node_nxt[i] = '0;
    end
    nodes_used = 1;
  endfunction

  // bump allocation, zero means the pool is exhausted
  function automatic logic [POS_W-1:0] grab_node(logic signed [VALUE_W-1:0] v);
    logic [POS_W-1:0] n;
    if (nodes_used >= POOL_NODES) return '0;
    n = nodes_used[POS_W-1:0];
    nodes_used++;
    node_val[n] = v;
    node_nxt[n] = '0;
    return n;
  endfunction

  function automatic int list_len();
    logic [POS_W-1:0] p;
    int len;
    p = node_nxt[0];
    len = 0;
    while (p != 0 && len < POOL_NODES) begin
      len++;
      p = node_nxt[p];
    end
    return len;
  endfunction

  function automatic logic signed [VALUE_W-1:0] nth_value(int k);
    logic [POS_W-1:0] p;
    p = node_nxt[0];
    for (int i = 0; i < k; i++) p = node_nxt[p];
    return node_val[p];
  endfunction

  // updates the pool for one command and queues the beats it produces
  function automatic void run_list_cmd(logic [CMD_W-1:0] cmd,
                                       logic signed [VALUE_W-1:0] v,
                                       logic [POS_W-1:0] pos);
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] p;
    int               steps;
    int               cnt;
    int               k;
    bit               hit;
    status_e          st;
    list_beat_t       beat;
    st    = ST_OK;
    p     = '0;
    steps = 0;
    case (cmd)
      CMD_CLEAR: begin
        nodes_used  = 1;
        node_nxt[0] = '0;
      end
      CMD_ADD_FRONT: begin
        n = grab_node(v);
        if (n == 0) st = ST_FULL;
        else begin
          node_nxt[n] = node_nxt[0];
          node_nxt[0] = n;
        end
      end
      CMD_ADD_BACK: begin
        n = grab_node(v);
        if (n == 0) st = ST_FULL;
        else begin
          while (node_nxt[p] != 0 && steps < POOL_NODES) begin
            p = node_nxt[p];
            steps++;
          end
          node_nxt[p] = n;
        end
      end
      CMD_ADD_POS: begin
        n = grab_node(v);
        if (n == 0) st = ST_FULL;
        else begin
          // position zero never matches, so it walks to the tail
          cnt = 1;
          while (node_nxt[p] != 0 && cnt != int'(pos) && steps < POOL_NODES) begin
            cnt++;
            p = node_nxt[p];
            steps++;
          end
          node_nxt[n] = node_nxt[p];
          node_nxt[p] = n;
        end
      end
      CMD_REMOVE: begin
        // stop in front of the first match and unlink only that node
        hit = 1'b0;
        while (node_nxt[p] != 0 && steps < POOL_NODES && !hit) begin
          n = node_nxt[p];
          if (node_val[n] == v) hit = 1'b1;
          else begin
            p = n;
            steps++;
          end
        end
        if (hit) node_nxt[p] = node_nxt[node_nxt[p]];
        else st = ST_NOT_FOUND;
      end
      CMD_READ: begin
        p = node_nxt[0];
        if (p == 0) st = ST_EMPTY;
        else begin
          k = 0;
          while (p != 0 && k < MAX_RESULTS) begin
            beat.value  = node_val[p];
            beat.status = ST_OK;
            beat.last   = (node_nxt[p] == 0 || k == MAX_RESULTS - 1);
            expected_beats.push_back(beat);
            k++;
            p = node_nxt[p];
          end
          return;
        end
      end
      default: ;
    endcase
    beat.value  = '0;
    beat.status = st;
    beat.last   = 1'b1;
    expected_beats.push_back(beat);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus, built at time zero against a private run of the model
  // ---------------------------------------------------------------------------

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v,
                                    logic [POS_W-1:0] pos, bit drain);
    list_cmd_t c;
    c.cmd   = cmd;
    c.value = v;
    c.pos   = pos;
    c.drain = drain;
    pending_cmds.push_back(c);
    run_list_cmd(cmd, v, pos);
    expected_beats.delete();
  endfunction

  // extremes, a narrow band that makes duplicates, or anything
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7, 0))
      0: begin
        case ($urandom_range(3, 0))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      1, 2:    return $signed($urandom_range(6, 0)) - 3;
      default: return $urandom;
    endcase
  endfunction

  initial begin : build_stimulus
    int               n_random;
    int               ops;
    int               roll;
    int               len;
    bit               fill;
    logic [POS_W-1:0] pos;
    pool_reset();

    // directed: empty list corners and spare codes
    queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd5, 6'd0, 1'b0);
    queue_cmd(CMD_SPARE_LO, 32'sh7fff_ffff, 6'd63, 1'b0);
    queue_cmd(CMD_SPARE_HI, 32'sh8000_0000, 6'd0, 1'b0);
    // directed: extreme values through every insert flavor
    queue_cmd(CMD_ADD_FRONT, 32'sh7fff_ffff, 6'd0, 1'b0);
    queue_cmd(CMD_ADD_BACK, 32'sh8000_0000, 6'd63, 1'b0);
    queue_cmd(CMD_ADD_POS, -32'sd1, 6'd1, 1'b0);
    queue_cmd(CMD_ADD_POS, 32'sd0, 6'd0, 1'b0);
    queue_cmd(CMD_ADD_POS, 32'sh5555_5555, 6'd63, 1'b0);
    queue_cmd(CMD_ADD_POS, 32'shaaaa_aaaa, 6'd2, 1'b0);
    queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);
    // directed: duplicates, only the first match goes
    queue_cmd(CMD_ADD_FRONT, -32'sd1, 6'd0, 1'b0);
    queue_cmd(CMD_REMOVE, -32'sd1, 6'd0, 1'b0);
    queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd12345, 6'd0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sh5555_5555, 6'd0, 1'b0);
    queue_cmd(CMD_REMOVE, -32'sd1, 6'd0, 1'b0);
    queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);
    // directed: clear keeps nothing visible, twice with a read between
    queue_cmd(CMD_CLEAR, 32'sd0, 6'd0, 1'b1);
    queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);
    queue_cmd(CMD_CLEAR, -32'sd1, 6'd63, 1'b0);
    queue_cmd(CMD_ADD_BACK, 32'sd7, 6'd0, 1'b0);
    queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);

    // random episodes: clear, build and edit, read back
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      if ($urandom_range(9, 0) != 0) begin
        queue_cmd(CMD_CLEAR, pick_value(), POS_W'($urandom_range(63, 0)),
                  n_random == 0 || $urandom_range(3, 0) == 0);
        n_random++;
      end
      fill = ($urandom_range(3, 0) == 0);
      ops  = fill ? $urandom_range(72, 66) : $urandom_range(30, 4);
      for (int j = 0; j < ops; j++) begin
        roll = $urandom_range(99, 0);
        if (fill) roll = (roll < 85) ? roll * 60 / 85 : roll - 7;
        len = list_len();
        pos = ($urandom_range(9, 0) < 7) ? POS_W'($urandom_range((len < 63) ? len + 1 : 63, 0))
                                         : POS_W'($urandom_range(63, 0));
        if (roll < 20) queue_cmd(CMD_ADD_FRONT, pick_value(), pos, 1'b0);
        else if (roll < 40) queue_cmd(CMD_ADD_BACK, pick_value(), pos, 1'b0);
        else if (roll < 60) queue_cmd(CMD_ADD_POS, pick_value(), pos, 1'b0);
        else if (roll < 78) begin
          if (len > 0 && $urandom_range(3, 0) != 0)
            queue_cmd(CMD_REMOVE, nth_value($urandom_range(len - 1, 0)), pos, 1'b0);
          else
            queue_cmd(CMD_REMOVE, pick_value(), pos, 1'b0);
        end else if (roll < 95) queue_cmd(CMD_READ, pick_value(), pos, 1'b0);
        else begin
          // noise: spare codes are ignored and do not count
          queue_cmd($urandom_range(1, 0) ? CMD_SPARE_HI : CMD_SPARE_LO, pick_value(), pos, 1'b0);
          n_random--;
        end
        n_random++;
      end
      queue_cmd(CMD_READ, 32'sd0, 6'd0, 1'b0);
      n_random++;
    end

    // the live run starts from a fresh pool
    pool_reset();
    expected_beats.delete();
  end

  // ---------------------------------------------------------------------------
  // command driver
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_cmds
    list_cmd_t nxt;
    int        idle_pct;
    bit        drained;
    if (rst_ni) begin
      if (start && !busy) begin
        run_list_cmd(cmd_i, value_i, position_i);
        cmds_accepted++;
        if (cmd_i == CMD_READ) reads_accepted++;
      end
      // sender gaps: moderate, then heavy, then none
      idle_pct = (cmds_accepted < 150) ? 29 : (cmds_accepted < 300) ? 59 : 0;
      drained  = (expected_beats.size() == 0) && !result_valid_o && !busy;
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && (!pending_cmds[0].drain || drained) &&
            $urandom_range(99, 0) >= idle_pct) begin
          nxt = pending_cmds.pop_front();
          start      <= 1'b1;
          cmd_i      <= nxt.cmd;
          value_i    <= nxt.value;
          position_i <= nxt.pos;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin : check_beats
    list_beat_t exp_beat;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        log_mismatch($sformatf("unexpected beat value %0d status %0d last %0b",
                               elem_value_o, status_o, last_o));
      end else begin
        exp_beat = expected_beats.pop_front();
        beats_checked++;
        if (elem_value_o !== exp_beat.value || status_o !== exp_beat.status ||
            last_o !== exp_beat.last)
          log_mismatch($sformatf("value %0d/%0d status %0d/%0d last %0b/%0b (exp/got)",
                                 exp_beat.value, elem_value_o, exp_beat.status, status_o,
                                 exp_beat.last, last_o));
      end
      if (status_o == ST_FULL) full_rejects++;
      if (status_o == ST_NOT_FOUND) missed_removes++;
      // length of each read-out
      if (status_o == ST_OK && elem_value_o !== 'x) read_run++;
      if (last_o) begin
        if (read_run > longest_read) longest_read = read_run;
        read_run = 0;
      end
    end
  end

  // watchdog on cycles where neither port moves a beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] timeout after %0d idle cycles", $realtime, stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------

  initial begin : finish_run
    wait (rst_ni === 1'b1);
    do @(posedge clk_i); while (pending_cmds.size() != 0 || start);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_beats.size() != 0)
      log_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
    $display("covered %0d commands (%0d read-outs, longest %0d elements), %0d beats checked",
             cmds_accepted, reads_accepted, longest_read, beats_checked);
    $display("pool-full rejects %0d, removes without a match %0d, mismatches %0d",
             full_rejects, missed_removes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
